// File: design/rnpp_pkg.sv
`default_nettype none

package rnpp_pkg;

    // largest revision that still parses
    localparam logic [30:0] REV_LIMIT = 31'h7FFF_FFFF;

    // reset value and ceiling of the name capacity register
    localparam logic [8:0] CAP_RESET = 9'd64;
    localparam logic [8:0] CAP_MAX   = 9'd256;

    // depth of the queue between the classifier and the parser
    localparam int QUEUE_DEPTH = 2;

    // register indexes on the configuration port
    localparam logic REG_NAME_CAPACITY = 1'b0;

    // characters the parser looks for
    localparam logic [7:0] CH_OPEN   = 8'h5B; // [
    localparam logic [7:0] CH_CLOSE  = 8'h5D; // ]
    localparam logic [7:0] CH_COMMA  = 8'h2C; // ,
    localparam logic [7:0] CH_QUOTE  = 8'h22; // "
    localparam logic [7:0] CH_BSLASH = 8'h5C; // backslash
    localparam logic [7:0] CH_SLASH  = 8'h2F; // /
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // one classified text byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_end;
        logic       is_space;
        logic       is_digit;
        logic [3:0] digit;
        logic       esc_ok;
        logic [7:0] esc_char;
    } t_word;

    function automatic t_word classify(input logic [7:0] c);
        t_word w;
        logic [7:0] d;
        d          = c - CH_ZERO;
        w.text_byte = c;
        w.is_end    = (c == 8'd0);
        w.is_space  = (c == 8'd32) || (c == 8'd9) || (c == 8'd10) || (c == 8'd13);
        w.is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        w.digit     = d[3:0];
        w.esc_ok    = 1'b1;
        unique case (c) inside
            CH_QUOTE, CH_BSLASH, CH_SLASH: w.esc_char = c;
            CH_N:    w.esc_char = 8'd10;
            CH_T:    w.esc_char = 8'd9;
            CH_R:    w.esc_char = 8'd13;
            CH_B:    w.esc_char = 8'd8;
            CH_F:    w.esc_char = 8'd12;
            default: begin
                w.esc_char = 8'd0;
                w.esc_ok   = 1'b0;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/rnpp_if.sv
`default_nettype none

// text byte channel
interface rnpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source(output valid, output text_byte, input ready);
    modport sink(input valid, input text_byte, output ready);
endinterface

// result channel
interface rnpp_out_if;
    logic        valid;
    logic        ready;
    logic        name_byte_valid;
    logic [7:0]  name_byte;
    logic        done_res;
    logic        ok;
    logic [30:0] revision;
    logic [7:0]  name_count;

    modport source(output valid, output name_byte_valid, output name_byte,
                   output done_res, output ok, output revision, output name_count,
                   input ready);
    modport sink(input valid, input name_byte_valid, input name_byte,
                 input done_res, input ok, input revision, input name_count,
                 output ready);
endinterface

`default_nettype wire

// File: design/rnpp_front.sv
`default_nettype none

module rnpp_front (
    rnpp_in_if.sink         i_text,
    output logic            o_push,
    output rnpp_pkg::t_word o_word,
    input  logic            i_push_ready
);
    import rnpp_pkg::*;

    // classify each byte on its way into the queue
    assign o_push       = i_text.valid;
    assign o_word       = classify(i_text.text_byte);
    assign i_text.ready = i_push_ready;

endmodule

`default_nettype wire

// File: design/rnpp_queue.sv
`default_nettype none

module rnpp_queue #(
    parameter int P_DEPTH = rnpp_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rnpp_pkg::t_word i_word,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output rnpp_pkg::t_word o_word,
    input  logic            i_pop
);
    import rnpp_pkg::*;

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(P_DEPTH);

    t_word         r_mem [P_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_push_ready = (r_count != FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_word       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/rnpp_back.sv
`default_nettype none

module rnpp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [8:0]      i_capacity,
    input  logic            i_word_valid,
    input  rnpp_pkg::t_word i_word,
    output logic            o_word_pop,
    rnpp_out_if.source      o_result
);
    import rnpp_pkg::*;

    localparam logic [3:0] PH_OPEN      = 4'd0;
    localparam logic [3:0] PH_REV_START = 4'd1;
    localparam logic [3:0] PH_REV       = 4'd2;
    localparam logic [3:0] PH_AFTER_REV = 4'd3;
    localparam logic [3:0] PH_VALUE     = 4'd4;
    localparam logic [3:0] PH_NULL      = 4'd5;
    localparam logic [3:0] PH_CLOSE     = 4'd6;
    localparam logic [3:0] PH_NAME      = 4'd7;
    localparam logic [3:0] PH_ESC       = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [30:0] r_rev, n_rev;
    logic [7:0]  r_count, n_count;
    logic [1:0]  r_null_pos, n_null_pos;
    logic        r_discard, n_discard;

    logic        r_out_valid;
    logic        r_nbv, r_done, r_ok;
    logic [7:0]  r_nb, r_cnt;
    logic [30:0] r_out_rev;

    logic        emit, done, good;
    logic [7:0]  ch, c, want, cnt_out;
    logic [8:0]  cap, next_len;
    logic [34:0] rev_x10;

    assign c = i_word.text_byte;
    assign o_word_pop = i_word_valid && (!r_out_valid || o_result.ready);

    // clamp capacity into 1..256
    always_comb begin
        if (i_capacity == 9'd0) begin
            cap = 9'd1;
        end else if (i_capacity > CAP_MAX) begin
            cap = CAP_MAX;
        end else begin
            cap = i_capacity;
        end
    end

    assign rev_x10  = {1'b0, r_rev, 3'b000} + {3'b000, r_rev, 1'b0} + {31'd0, i_word.digit};
    assign next_len = {1'b0, r_count} + 9'd1;
    assign want     = (r_null_pos == 2'd1) ? CH_U : CH_L;

    always_comb begin
        n_phase    = r_phase;
        n_rev      = r_rev;
        n_count    = r_count;
        n_null_pos = r_null_pos;
        n_discard  = r_discard;
        emit       = 1'b0;
        done       = 1'b0;
        good       = 1'b0;
        ch         = 8'd0;

        if (r_discard) begin
            if (i_word.is_end) begin
                n_phase    = PH_OPEN;
                n_rev      = '0;
                n_count    = '0;
                n_null_pos = '0;
                n_discard  = 1'b0;
            end
        end else if (i_word.is_end) begin
            done = 1'b1;
        end else begin
            unique case (r_phase) inside
                PH_OPEN: begin
                    if (c == CH_OPEN) begin
                        n_phase = PH_REV_START;
                    end else if (!i_word.is_space) begin
                        done = 1'b1;
                    end
                end
                PH_REV_START: begin
                    if (i_word.is_digit) begin
                        n_rev   = {27'd0, i_word.digit};
                        n_phase = PH_REV;
                    end else if (!i_word.is_space) begin
                        done = 1'b1;
                    end
                end
                PH_REV, PH_AFTER_REV: begin
                    if (r_phase == PH_REV && i_word.is_digit) begin
                        if (rev_x10 > {4'd0, REV_LIMIT}) begin
                            done = 1'b1;
                        end else begin
                            n_rev = rev_x10[30:0];
                        end
                    end else if (c == CH_CLOSE) begin
                        done = 1'b1;
                        good = 1'b1;
                    end else if (c == CH_COMMA) begin
                        n_phase = PH_VALUE;
                    end else if (i_word.is_space) begin
                        n_phase = PH_AFTER_REV;
                    end else begin
                        done = 1'b1;
                    end
                end
                PH_VALUE: begin
                    if (c == CH_N) begin
                        n_null_pos = 2'd1;
                        n_phase    = PH_NULL;
                    end else if (c == CH_QUOTE) begin
                        n_phase = PH_NAME;
                    end else if (!i_word.is_space) begin
                        done = 1'b1;
                    end
                end
                PH_NULL: begin
                    if (c != want) begin
                        done = 1'b1;
                    end else if (r_null_pos == 2'd3) begin
                        n_null_pos = 2'd0;
                        n_phase    = PH_CLOSE;
                    end else begin
                        n_null_pos = r_null_pos + 2'd1;
                    end
                end
                PH_CLOSE: begin
                    if (c == CH_CLOSE) begin
                        done = 1'b1;
                        good = 1'b1;
                    end else if (!i_word.is_space) begin
                        done = 1'b1;
                    end
                end
                PH_NAME: begin
                    if (c == CH_QUOTE) begin
                        n_phase = PH_CLOSE;
                    end else if (c == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        emit = 1'b1;
                        ch   = c;
                    end
                end
                PH_ESC: begin
                    n_phase = PH_NAME;
                    if (i_word.esc_ok) begin
                        emit = 1'b1;
                        ch   = i_word.esc_char;
                    end else begin
                        done = 1'b1;
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase

            // name length check
            if (emit) begin
                if (next_len >= cap) begin
                    emit = 1'b0;
                    ch   = 8'd0;
                    done = 1'b1;
                end else begin
                    n_count = next_len[7:0];
                end
            end
        end

        cnt_out = n_count;

        // end of string restarts at once, any other deciding byte starts a discard
        if (done) begin
            if (i_word.is_end) begin
                n_phase    = PH_OPEN;
                n_rev      = '0;
                n_count    = '0;
                n_null_pos = '0;
                n_discard  = 1'b0;
            end else begin
                n_discard = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPEN;
            r_rev       <= '0;
            r_count     <= '0;
            r_null_pos  <= '0;
            r_discard   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_word_pop) begin
                r_phase    <= n_phase;
                r_rev      <= n_rev;
                r_count    <= n_count;
                r_null_pos <= n_null_pos;
                r_discard  <= n_discard;
            end
            if (o_word_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_word_pop) begin
            r_nbv     <= emit;
            r_nb      <= ch;
            r_done    <= done;
            r_ok      <= done && good;
            r_out_rev <= (done && good) ? r_rev : 31'd0;
            r_cnt     <= cnt_out;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.name_byte_valid = r_nbv;
    assign o_result.name_byte       = r_nb;
    assign o_result.done_res        = r_done;
    assign o_result.ok              = r_ok;
    assign o_result.revision        = r_out_rev;
    assign o_result.name_count      = r_cnt;

endmodule

`default_nettype wire

// File: design/revision_name_pair_parser_top.sv
`default_nettype none

// Parses text of the form [revision], [revision,null] or [revision,"name"],
// one byte per word on i_text, and gives exactly one result word on o_result
// for every text word. It takes one byte per cycle, back to back, while the
// queue has room: the classifier feeds a small queue (P_QUEUE_DEPTH words)
// and the parser drains it into a single output register, so a new byte is
// taken while the last result still waits. A text word passes the queue and
// then the output register. Name bytes come out as they are decoded; the
// deciding byte gives done_res with ok and, on success, the revision. After a
// decision everything up to and including the zero byte is swallowed, then
// parsing starts over. The name capacity register (address 0, 9 bits, reset
// 64) must only be written while the block is idle.
module revision_name_pair_parser_top #(
    parameter int P_QUEUE_DEPTH = rnpp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rnpp_in_if.sink     i_text,
    rnpp_out_if.source  o_result,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rnpp_pkg::*;

    logic       r_capacity;
    logic [8:0] r_cap;

    logic  push, push_ready, pop_valid, pop;
    t_word push_word, pop_word;

    // register file: only the name capacity lives here
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NAME_CAPACITY) ? {23'd0, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RESET;
            r_capacity <= 1'b0;
        end else begin
            // r_capacity marks that the register has been written since reset
            if (psel && penable && pwrite && pready
                && paddr[2] == REG_NAME_CAPACITY) begin
                r_cap      <= pwdata[8:0];
                r_capacity <= 1'b1;
            end
        end
    end

    // front: classify each byte
    rnpp_front u_front (
        .i_text       (i_text),
        .o_push       (push),
        .o_word       (push_word),
        .i_push_ready (push_ready)
    );

    // queue between classifier and parser
    rnpp_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_word       (push_word),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_word       (pop_word),
        .i_pop        (pop)
    );

    // back: parser state and result register
    rnpp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_capacity   (r_capacity ? r_cap : CAP_RESET),
        .i_word_valid (pop_valid),
        .i_word       (pop_word),
        .o_word_pop   (pop),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire

// File: bench/tb_revision_name_pair_parser_top.sv
`timescale 1ns / 1ps

module tb_revision_name_pair_parser_top;
    import rnpp_pkg::*;

    localparam time CLK_HALF     = 6ns;
    localparam int  RESET_CYCLES = 6;
    // extra wait once every owed result has come out
    localparam int  DRAIN_CYCLES = 8;
    localparam int  DRAIN_LIMIT  = 20000;
    localparam int  REPORT_LIMIT = 10;
    localparam time RUN_LIMIT    = 12ms;
    localparam logic [2:0] CAP_ADDR = 3'(REG_NAME_CAPACITY) * 3'd4;
    localparam string ESC_LETTERS = "\"\\/ntrbf";

    // parser position, mirrors the block's phases
    typedef enum logic [3:0] {
        PS_OPEN,
        PS_REV_START,
        PS_REV,
        PS_AFTER_REV,
        PS_VALUE,
        PS_NULL,
        PS_CLOSE,
        PS_NAME,
        PS_ESC
    } t_parse_state;

    // one result word as the block should give it
    typedef struct packed {
        logic        name_byte_valid;
        logic [7:0]  name_byte;
        logic        done_res;
        logic        ok;
        logic [30:0] revision;
        logic [7:0]  name_count;
    } t_result_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rnpp_in_if  text_ch();
    rnpp_out_if result_ch();

    revision_name_pair_parser_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (text_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // parser shadow state
    t_parse_state ps_state;
    logic [30:0]  ps_rev;
    logic [7:0]   ps_count;
    logic [1:0]   ps_null_pos;
    logic         ps_discard;
    logic [8:0]   ps_capacity;

    // results still owed by the block, oldest first
    t_result_word owed_results[$];
    // text of the pair being built
    logic [7:0]   text_buf[$];

    int send_idle_pct;
    int stall_pct;
    int hold_off_req;
    int hold_off_left;
    int fail_count;
    int words_sent;
    int live_words;
    int pairs_ok;
    int pairs_bad;
    int name_bytes;
    int input_stall_cycles;

    // ------------------------------------------------------------------
    // parser prediction
    // ------------------------------------------------------------------

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void parse_restart();
        ps_state    = PS_OPEN;
        ps_rev      = '0;
        ps_count    = '0;
        ps_null_pos = '0;
        ps_discard  = 1'b0;
    endfunction

    // advance the shadow parser by one text byte, return the result word
    function automatic t_result_word parse_text_byte(input logic [7:0] c);
        t_result_word w;
        int           cap;
        logic         emit;
        logic         done;
        logic         good;
        logic [7:0]   ch;
        logic [7:0]   want;
        logic [63:0]  grown;
        emit = 1'b0;
        done = 1'b0;
        good = 1'b0;
        ch   = '0;
        // out-of-range capacities are clamped
        cap  = int'(ps_capacity);
        if (cap == 0) cap = 1;
        if (cap > 256) cap = 256;

        if (ps_discard) begin
            // swallow everything up to the terminating zero
            if (c == 8'd0) parse_restart();
        end else if (c == 8'd0) begin
            // early end of string
            done = 1'b1;
        end else begin
            case (ps_state) inside
                PS_OPEN: begin
                    if (c == CH_OPEN) ps_state = PS_REV_START;
                    else if (!is_blank(c)) done = 1'b1;
                end
                PS_REV_START: begin
                    if (is_digit(c)) begin
                        ps_rev   = 31'(c - CH_ZERO);
                        ps_state = PS_REV;
                    end else if (!is_blank(c)) begin
                        done = 1'b1;
                    end
                end
                PS_REV, PS_AFTER_REV: begin
                    if (ps_state == PS_REV && is_digit(c)) begin
                        grown = 64'(ps_rev) * 64'd10 + 64'(c - CH_ZERO);
                        if (grown > 64'(REV_LIMIT)) done = 1'b1;
                        else ps_rev = grown[30:0];
                    end else if (c == CH_CLOSE) begin
                        done = 1'b1;
                        good = 1'b1;
                    end else if (c == CH_COMMA) begin
                        ps_state = PS_VALUE;
                    end else if (is_blank(c)) begin
                        ps_state = PS_AFTER_REV;
                    end else begin
                        done = 1'b1;
                    end
                end
                PS_VALUE: begin
                    if (c == CH_N) begin
                        ps_null_pos = 2'd1;
                        ps_state    = PS_NULL;
                    end else if (c == CH_QUOTE) begin
                        ps_state = PS_NAME;
                    end else if (!is_blank(c)) begin
                        done = 1'b1;
                    end
                end
                PS_NULL: begin
                    want = (ps_null_pos == 2'd1) ? CH_U : CH_L;
                    if (c != want) begin
                        done = 1'b1;
                    end else if (ps_null_pos == 2'd3) begin
                        ps_null_pos = '0;
                        ps_state    = PS_CLOSE;
                    end else begin
                        ps_null_pos = ps_null_pos + 2'd1;
                    end
                end
                PS_CLOSE: begin
                    if (c == CH_CLOSE) begin
                        done = 1'b1;
                        good = 1'b1;
                    end else if (!is_blank(c)) begin
                        done = 1'b1;
                    end
                end
                PS_NAME: begin
                    if (c == CH_QUOTE) ps_state = PS_CLOSE;
                    else if (c == CH_BSLASH) ps_state = PS_ESC;
                    else begin
                        emit = 1'b1;
                        ch   = c;
                    end
                end
                default: begin
                    ps_state = PS_NAME;
                    emit     = 1'b1;
                    case (c) inside
                        CH_QUOTE, CH_BSLASH, CH_SLASH: ch = c;
                        CH_N:    ch = 8'd10;
                        CH_T:    ch = 8'd9;
                        CH_R:    ch = 8'd13;
                        CH_B:    ch = 8'd8;
                        CH_F:    ch = 8'd12;
                        default: begin
                            emit = 1'b0;
                            done = 1'b1;
                        end
                    endcase
                end
            endcase
            // the name must stay below the capacity
            if (emit) begin
                if (int'(ps_count) + 1 >= cap) begin
                    emit = 1'b0;
                    ch   = '0;
                    done = 1'b1;
                end else begin
                    ps_count = ps_count + 8'd1;
                end
            end
        end

        w.name_byte_valid = emit;
        w.name_byte       = emit ? ch : 8'd0;
        w.done_res        = done;
        w.ok              = done && good;
        w.revision        = (done && good) ? ps_rev : 31'd0;
        w.name_count      = ps_count;

        if (done) begin
            if (c == 8'd0) parse_restart();
            else ps_discard = 1'b1;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // text building
    // ------------------------------------------------------------------

    function automatic void put_char(input logic [7:0] c);
        text_buf.push_back(c);
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    // mostly no whitespace, sometimes one or two of the four kinds
    function automatic void put_blanks();
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(3))
                    0:       put_char(8'd32);
                    1:       put_char(8'd9);
                    2:       put_char(8'd10);
                    default: put_char(8'd13);
                endcase
            end
        end
    endfunction

    function automatic void put_revision();
        case ($urandom_range(7))
            0:       put_str("0");
            1:       put_str("2147483647");
            2:       put_str($sformatf("%0d", 64'd2147483648 + $urandom_range(0, 100000)));
            3:       put_str($sformatf("%0d", $urandom() & 32'h7FFF_FFFF));
            4:       put_str($sformatf("00%0d", $urandom_range(0, 99)));
            default: put_str($sformatf("%0d", $urandom_range(0, 9999)));
        endcase
    endfunction

    // name characters of any nonzero byte but quote and backslash, with valid and invalid escapes
    function automatic void put_name_chars(input int len);
        logic [7:0] b;
        repeat (len) begin
            if ($urandom_range(9) == 0) begin
                put_char(CH_BSLASH);
                if ($urandom_range(19) == 0) put_char(8'($urandom_range(1, 255)));
                else put_char(ESC_LETTERS[$urandom_range(7)]);
            end else begin
                do b = 8'($urandom_range(1, 255));
                while (b == CH_QUOTE || b == CH_BSLASH);
                put_char(b);
            end
        end
    endfunction

    function automatic void put_name_pair(input int len);
        put_str("[4,\"");
        put_name_chars(len);
        put_str("\"]");
        put_char(8'd0);
    endfunction

    // one string: mostly well-formed pairs, some noise and broken ones
    function automatic void put_random_pair(input int eff_cap);
        int form;
        int len;
        int cut;
        form = $urandom_range(99);
        if (form < 8) begin
            repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(1, 255)));
        end else begin
            put_blanks();
            put_char(CH_OPEN);
            put_blanks();
            put_revision();
            put_blanks();
            case ($urandom_range(2))
                0: ;
                1: begin
                    put_char(CH_COMMA);
                    put_blanks();
                    put_str("null");
                end
                default: begin
                    case ($urandom_range(19)) inside
                        0:       len = eff_cap - 2 + $urandom_range(2);
                        1, 2:    len = $urandom_range(0, 40);
                        default: len = $urandom_range(0, 6);
                    endcase
                    if (len < 0) len = 0;
                    put_char(CH_COMMA);
                    put_blanks();
                    put_char(CH_QUOTE);
                    put_name_chars(len);
                    put_char(CH_QUOTE);
                end
            endcase
            put_blanks();
            put_char(CH_CLOSE);
            if ($urandom_range(3) == 0) put_str(" tail");
            cut = $urandom_range(text_buf.size() - 1);
            if (form < 20) begin
                // one byte overwritten, a zero among them
                text_buf[cut] = 8'($urandom_range(0, 255));
            end else if (form < 28) begin
                while (text_buf.size() > cut) void'(text_buf.pop_back());
            end
        end
        put_char(8'd0);
    endfunction

    // ------------------------------------------------------------------
    // drivers and monitor
    // ------------------------------------------------------------------

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // offer one text word, predict its result once it is taken
    task automatic send_text_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            text_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        do @(posedge i_clk); while (!text_ch.ready);
        if (!ps_discard) live_words++;
        words_sent++;
        owed_results.push_back(parse_text_byte(b));
    endtask

    task automatic flush_text();
        logic [7:0] b;
        while (text_buf.size() != 0) begin
            b = text_buf.pop_front();
            send_text_byte(b);
        end
    endtask

    // drop valid, then let every owed result come out
    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge i_clk);
        text_ch.valid <= 1'b0;
        while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write of the name capacity, then read it back
    task automatic set_capacity(input logic [8:0] value);
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        ps_capacity = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[8:0] !== value)
            note_failure($sformatf("capacity read back %0d, wrote %0d", prdata[8:0], value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side ready; a requested hold-off keeps it low for a counted stretch
    always @(negedge i_clk) begin
        if (hold_off_req > 0) begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end
        if (hold_off_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each result word with the oldest owed one
    always @(posedge i_clk) begin : check_results
        t_result_word got;
        t_result_word want;
        if (i_rst_n) begin
            if (text_ch.valid && !text_ch.ready) input_stall_cycles++;
            if (result_ch.valid && result_ch.ready) begin
                got.name_byte_valid = result_ch.name_byte_valid;
                got.name_byte       = result_ch.name_byte;
                got.done_res        = result_ch.done_res;
                got.ok              = result_ch.ok;
                got.revision        = result_ch.revision;
                got.name_count      = result_ch.name_count;
                if (owed_results.size() == 0) begin
                    note_failure($sformatf("result word with nothing owed: %h", got));
                end else begin
                    want = owed_results.pop_front();
                    if (want.done_res) begin
                        if (want.ok) pairs_ok++;
                        else pairs_bad++;
                    end
                    if (want.name_byte_valid) name_bytes++;
                    if (got !== want)
                        note_failure($sformatf({"expected nbv=%0b byte=%02h done=%0b ok=%0b",
                            " rev=%0d cnt=%0d, got nbv=%0b byte=%02h done=%0b ok=%0b",
                            " rev=%0d cnt=%0d"},
                            want.name_byte_valid, want.name_byte, want.done_res, want.ok,
                            want.revision, want.name_count,
                            got.name_byte_valid, got.name_byte, got.done_res, got.ok,
                            got.revision, got.name_count));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // one short string per case, each ended by a zero byte
    task automatic test_directed_pairs();
        string cases[$];
        cases = '{
            "[0]",
            "[2147483647]",
            "[2147483648]",
            "[99999999999999]",
            " \t\r\n[ 42 , null ] trailing",
            "[7,\"Az\377\001\"]",
            "[3,\"\\\"\\\\\\/\\n\\t\\r\\b\\f\"]",
            "[3,\"\\q\"]",
            "[1,nux]",
            "[1,nul",
            "[5",
            "",
            "x[1]",
            "[,1]",
            "[12 3]",
            "[1,\"\"]",
            "[8,]",
            "[8,null,]",
            "[6] ]] garbage"
        };
        foreach (cases[i]) begin
            put_str(cases[i]);
            put_char(8'd0);
        end
        flush_text();
    endtask

    // names right at and just over the limit, clamped capacities
    task automatic test_capacity_edges();
        // capacity one: only the empty name fits
        set_capacity(9'd1);
        put_name_pair(0);
        put_name_pair(1);
        flush_text();
        set_capacity(9'd2);
        put_name_pair(1);
        put_str("[2,\"\\n\\t\"]");
        put_char(8'd0);
        flush_text();
        // largest capacity holds the longest name
        set_capacity(CAP_MAX);
        put_name_pair(255);
        flush_text();
        // above the largest capacity clamps, one more character fails
        set_capacity(9'd300);
        put_name_pair(256);
        flush_text();
    endtask

    task automatic test_random_pairs(input int idle, input int stall, input logic [8:0] cap,
                                     input int target);
        int eff_cap;
        int start;
        set_capacity(cap);
        send_idle_pct = idle;
        stall_pct     = stall;
        eff_cap = (cap == 0) ? 1 : (cap > 256) ? 256 : int'(cap);
        start   = live_words;
        while (live_words - start < target) begin
            put_random_pair(eff_cap);
            flush_text();
        end
    endtask

    // result side holds off long enough for the block to back up its input
    task automatic test_result_hold_off();
        set_capacity(CAP_RESET);
        send_idle_pct = 0;
        stall_pct     = 0;
        put_random_pair(64);
        flush_text();
        hold_off_req = 400;
        repeat (12) begin
            put_random_pair(64);
            flush_text();
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = '0;
        result_ch.ready   = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        hold_off_req      = 0;
        hold_off_left     = 0;
        ps_capacity       = CAP_RESET;
        parse_restart();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_pairs();
        test_capacity_edges();
        // back to back, sender gaps, result stalls, then both together
        test_random_pairs(0, 0, CAP_RESET, 170);
        test_random_pairs(82, 0, 9'd9, 170);
        test_random_pairs(0, 82, 9'd0, 170);
        test_random_pairs(26, 26, 9'd511, 170);
        test_result_hold_off();

        wait_drained();
        if (owed_results.size() != 0)
            note_failure($sformatf("%0d result words never arrived", owed_results.size()));

        $display("covered %0d text words (%0d parsed), %0d pairs accepted, %0d rejected",
                 words_sent, live_words, pairs_ok, pairs_bad);
        $display("%0d name bytes, capacities 0 to 511, input stalled %0d cycles, %0d failures",
                 name_bytes, input_stall_cycles, fail_count);
        if (fail_count == 0) begin
            $display("tb_revision_name_pair_parser_top: PASS");
        end else begin
            $display("tb_revision_name_pair_parser_top: FAIL");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT);
        $display("timeout with %0d result words owed", owed_results.size());
        $display("tb_revision_name_pair_parser_top: FAIL");
        $finish;
    end

endmodule
